// File: design/stb_pkg.sv
`default_nettype none

package stb_pkg;

    // Request field widths
    localparam int OP_W      = 3;
    localparam int INDEX_W   = 3;
    localparam int TICK_W    = 16;
    localparam int MS_W      = 32;
    localparam int MASK_W    = 8;

    // Width used to compare a timer index against timer positions
    localparam int SEL_W     = 6;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_TICK        = 3'd0,
        OP_START       = 3'd1,
        OP_STOP        = 3'd2,
        OP_RESTART     = 3'd3,
        OP_FORCE       = 3'd4,
        OP_SET_TIMEOUT = 3'd5
    } stb_op_t;

endpackage

`default_nettype wire

// File: design/soft_timer_bank.sv
`default_nettype none

// Channel   Handshake                  Payload
// -------   -------------------------  ----------------------------------------------
// in        in_valid / in_stall        opcode, timer_index, tick_ms, timeout_value
// out       out_valid / out_stall      now_ms, enabled_mask, expired_mask
//
// From acceptance to result a request passes the input register; then the timer
// update and status masks are registered into the result register.
// A new request is accepted every cycle while the result side keeps up; the
// tick path (32-bit add, then one subtract-compare per timer) sets the cycle.
// Reset clears the counter, all stamps, timeouts, enable and expired bits.
// A stalled result holds; in_stall rises only when the input register is full
// and cannot move on.

module soft_timer_bank #(
    parameter int NUM_TIMERS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [stb_pkg::OP_W-1:0]      opcode,
    input  wire logic [stb_pkg::INDEX_W-1:0]   timer_index,
    input  wire logic [stb_pkg::TICK_W-1:0]    tick_ms,
    input  wire logic [stb_pkg::MS_W-1:0]      timeout_value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [stb_pkg::MS_W-1:0]           now_ms,
    output logic [stb_pkg::MASK_W-1:0]         enabled_mask,
    output logic [stb_pkg::MASK_W-1:0]         expired_mask
);

    import stb_pkg::*;

    localparam int MASK_N = (NUM_TIMERS < MASK_W) ? NUM_TIMERS : MASK_W;

    // Input register
    logic                 in_valid_reg;
    logic [OP_W-1:0]      opcode_reg;
    logic [INDEX_W-1:0]   timer_index_reg;
    logic [TICK_W-1:0]    tick_ms_reg;
    logic [MS_W-1:0]      timeout_value_reg;

    // Timer state
    logic [MS_W-1:0]       ms_counter_reg;
    logic [MS_W-1:0]       ms_counter_next;
    logic [MS_W-1:0]       start_stamp_reg   [NUM_TIMERS];
    logic [MS_W-1:0]       start_stamp_next  [NUM_TIMERS];
    logic [MS_W-1:0]       timeout_reg       [NUM_TIMERS];
    logic [MS_W-1:0]       timeout_next      [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] enable_reg;
    logic [NUM_TIMERS-1:0] enable_next;
    logic [NUM_TIMERS-1:0] expired_reg;
    logic [NUM_TIMERS-1:0] expired_next;

    // Result register
    logic                 out_valid_reg;
    logic [MS_W-1:0]      now_ms_reg;
    logic [MASK_W-1:0]    enabled_mask_reg;
    logic [MASK_W-1:0]    expired_mask_reg;
    logic [MASK_W-1:0]    en_mask_next;
    logic [MASK_W-1:0]    ex_mask_next;

    logic                 advance;
    logic [MS_W-1:0]      sum;
    logic [MS_W-1:0]      stamp_now;

    // Handshake: the input register moves on when the result slot is empty or its result is taken
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign now_ms       = now_ms_reg;
    assign enabled_mask = enabled_mask_reg;
    assign expired_mask = expired_mask_reg;

    // Counter advance, skipping zero
    assign sum       = ms_counter_reg + MS_W'(tick_ms_reg);
    assign stamp_now = (ms_counter_reg == '0) ? MS_W'(1) : ms_counter_reg;

    // Next timer state for the request in the input register
    always_comb
    begin
        ms_counter_next = ms_counter_reg;
        enable_next     = enable_reg;
        expired_next    = expired_reg;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            start_stamp_next[i] = start_stamp_reg[i];
            timeout_next[i]     = timeout_reg[i];
        end

        if (opcode_reg == OP_TICK)
        begin
            ms_counter_next = (sum == '0) ? MS_W'(1) : sum;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                // wrap-safe elapsed time against the timeout
                if (enable_reg[i] && !expired_reg[i]
                    && ((ms_counter_next - start_stamp_reg[i]) >= timeout_reg[i]))
                begin
                    expired_next[i]     = 1'b1;
                    start_stamp_next[i] = '0;
                end
            end
        end
        else
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                if (SEL_W'(timer_index_reg) == SEL_W'(i))
                begin
                    case (opcode_reg)
                        OP_START:
                        begin
                            enable_next[i]      = 1'b1;
                            start_stamp_next[i] = stamp_now;
                            expired_next[i]     = 1'b0;
                        end
                        OP_STOP:
                        begin
                            enable_next[i] = 1'b0;
                        end
                        OP_RESTART:
                        begin
                            start_stamp_next[i] = stamp_now;
                            expired_next[i]     = 1'b0;
                        end
                        OP_FORCE:
                        begin
                            expired_next[i]     = 1'b1;
                            start_stamp_next[i] = '0;
                        end
                        OP_SET_TIMEOUT:
                        begin
                            timeout_next[i] = timeout_value_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    // Status masks from the updated state
    always_comb
    begin
        en_mask_next = '0;
        ex_mask_next = '0;
        for (int k = 0; k < MASK_N; k++)
        begin
            en_mask_next[k] = enable_next[k];
            ex_mask_next[k] = enable_next[k] && expired_next[k];
        end
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            opcode_reg        <= opcode;
            timer_index_reg   <= timer_index;
            tick_ms_reg       <= tick_ms;
            timeout_value_reg <= timeout_value;
        end
    end

    // Timer state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_counter_reg <= '0;
            enable_reg     <= '0;
            expired_reg    <= '0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                start_stamp_reg[i] <= '0;
                timeout_reg[i]     <= '0;
            end
        end
        else if (advance)
        begin
            ms_counter_reg <= ms_counter_next;
            enable_reg     <= enable_next;
            expired_reg    <= expired_next;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                start_stamp_reg[i] <= start_stamp_next[i];
                timeout_reg[i]     <= timeout_next[i];
            end
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            now_ms_reg       <= ms_counter_next;
            enabled_mask_reg <= en_mask_next;
            expired_mask_reg <= ex_mask_next;
        end
    end

endmodule

`default_nettype wire

// File: sim/soft_timer_bank_tb.sv
`default_nettype none

module soft_timer_bank_tb;

    import stb_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int TIMER_COUNT  = 8;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 8;

    // Opcodes the block treats as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    // Receiver stall patterns
    localparam int STALL_NONE     = 0;
    localparam int STALL_RANDOM   = 1;
    localparam int STALL_PERIODIC = 2;
    localparam int STALL_HEAVY    = 3;

    typedef struct packed {
        logic [MS_W-1:0]   now;
        logic [MASK_W-1:0] enabled;
        logic [MASK_W-1:0] expired;
    } timer_status_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [OP_W-1:0]      opcode = '0;
    logic [INDEX_W-1:0]   timer_index = '0;
    logic [TICK_W-1:0]    tick_ms = '0;
    logic [MS_W-1:0]      timeout_value = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [MS_W-1:0]      now_ms;
    logic [MASK_W-1:0]    enabled_mask;
    logic [MASK_W-1:0]    expired_mask;

    // Shadow copy of the timer bank
    logic [MS_W-1:0]        bank_ms;
    logic [MS_W-1:0]        bank_stamp [TIMER_COUNT];
    logic [MS_W-1:0]        bank_timeout [TIMER_COUNT];
    logic [TIMER_COUNT-1:0] bank_enable;
    logic [TIMER_COUNT-1:0] bank_expired;

    timer_status_t expected_status [$];
    timer_status_t seen_status;

    bit failed = 1'b0;
    int cycle_count = 0;
    int sent_count = 0;
    int burst_left = 0;
    bit sender_idle = 1'b0;
    int stall_mode = STALL_NONE;
    int stall_phase = 0;

    soft_timer_bank #(
        .NUM_TIMERS(TIMER_COUNT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .opcode(opcode),
        .timer_index(timer_index),
        .tick_ms(tick_ms),
        .timeout_value(timeout_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .now_ms(now_ms),
        .enabled_mask(enabled_mask),
        .expired_mask(expired_mask)
    );

    always #(CLK_HALF) clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("soft_timer_bank_tb: FAIL");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1;
        case (stall_mode)
            STALL_RANDOM:   out_stall <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: out_stall <= ((stall_phase % 11) < 4);
            STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
            default:        out_stall <= 1'b0;
        endcase
    end

    // Result checker: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_status.size() == 0)
            begin
                $display("%0t: unexpected result now_ms=%h enabled=%h expired=%h",
                         $time, now_ms, enabled_mask, expired_mask);
                failed = 1'b1;
            end
            else
            begin
                seen_status = expected_status.pop_front();
                if (now_ms !== seen_status.now)
                begin
                    $display("%0t: now_ms expected %h actual %h",
                             $time, seen_status.now, now_ms);
                    failed = 1'b1;
                end
                if (enabled_mask !== seen_status.enabled)
                begin
                    $display("%0t: enabled_mask expected %h actual %h",
                             $time, seen_status.enabled, enabled_mask);
                    failed = 1'b1;
                end
                if (expired_mask !== seen_status.expired)
                begin
                    $display("%0t: expired_mask expected %h actual %h",
                             $time, seen_status.expired, expired_mask);
                    failed = 1'b1;
                end
            end
        end
    end

    // Apply one request to the shadow bank and return the status it reports
    task automatic advance_bank(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                                input logic [TICK_W-1:0] ms, input logic [MS_W-1:0] tmo,
                                output timer_status_t st);
        logic [MS_W-1:0] stamp_val;
        logic [MS_W-1:0] elapsed;
        // a start stamp is never zero
        stamp_val = (bank_ms == '0) ? 32'd1 : bank_ms;
        case (op)
            OP_TICK:
            begin
                bank_ms = bank_ms + ms;
                if (bank_ms == '0)
                    bank_ms = 32'd1;
                for (int i = 0; i < TIMER_COUNT; i++)
                begin
                    if (bank_enable[i] && !bank_expired[i])
                    begin
                        elapsed = bank_ms - bank_stamp[i];
                        if (elapsed >= bank_timeout[i])
                        begin
                            bank_expired[i] = 1'b1;
                            bank_stamp[i] = '0;
                        end
                    end
                end
            end
            OP_START:
            begin
                bank_enable[idx] = 1'b1;
                bank_stamp[idx] = stamp_val;
                bank_expired[idx] = 1'b0;
            end
            OP_STOP:
                bank_enable[idx] = 1'b0;
            OP_RESTART:
            begin
                bank_stamp[idx] = stamp_val;
                bank_expired[idx] = 1'b0;
            end
            OP_FORCE:
            begin
                bank_expired[idx] = 1'b1;
                bank_stamp[idx] = '0;
            end
            OP_SET_TIMEOUT:
                bank_timeout[idx] = tmo;
            default:
                ;
        endcase
        st.now = bank_ms;
        st.enabled = bank_enable;
        st.expired = bank_enable & bank_expired;
    endtask

    // Drive one request, wait for acceptance, record its expected status
    task automatic send_request(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                                input logic [TICK_W-1:0] ms, input logic [MS_W-1:0] tmo);
        timer_status_t st;
        int gap;
        if (sender_idle)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(1, 6);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = burst_left - 1;
        end
        opcode <= op;
        timer_index <= idx;
        tick_ms <= ms;
        timeout_value <= tmo;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_bank(op, idx, ms, tmo, st);
        expected_status.push_back(st);
        sent_count++;
    endtask

    // Mostly short ticks so timers expire within a few requests
    function automatic logic [TICK_W-1:0] random_tick();
        if ($urandom_range(0, 1) == 0)
            return TICK_W'($urandom_range(0, 2000));
        return TICK_W'($urandom_range(0, 65535));
    endfunction

    // Commands before the counter has ever advanced, then the first tick of 0 ms
    task automatic test_before_first_tick;
        send_request(OP_START, 3'd0, 16'd0, 32'd0);
        send_request(OP_FORCE, 3'd7, 16'd0, 32'd0);
        send_request(OP_TICK, 3'd0, 16'd0, 32'd0);
    endtask

    // Each command, with timeouts at both ends of the range
    task automatic test_command_effects;
        send_request(OP_SET_TIMEOUT, 3'd1, 16'd0, 32'hFFFF_FFFF);
        send_request(OP_START, 3'd1, 16'd0, 32'd0);
        send_request(OP_TICK, 3'd0, 16'hFFFF, 32'd0);
        send_request(OP_RESTART, 3'd0, 16'd0, 32'd0);
        send_request(OP_STOP, 3'd0, 16'd0, 32'd0);
        send_request(OP_RESTART, 3'd2, 16'd0, 32'd0);
        send_request(OP_START, 3'd7, 16'd0, 32'd0);
        send_request(OP_SET_TIMEOUT, 3'd7, 16'd0, 32'd100);
        send_request(OP_TICK, 3'd0, 16'd99, 32'd0);
        send_request(OP_TICK, 3'd0, 16'd1, 32'd0);
        send_request(OP_FORCE, 3'd1, 16'd0, 32'd0);
        send_request(OP_STOP, 3'd7, 16'd0, 32'd0);
        send_request(OP_START, 3'd7, 16'd0, 32'd0);
    endtask

    // Spare opcodes change nothing; alternating bit patterns on the fields
    task automatic test_unused_opcodes;
        send_request(OP_SPARE_LO, 3'd3, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(OP_SPARE_HI, 3'd5, 16'h1234, 32'h0BAD_F00D);
        send_request(OP_SET_TIMEOUT, 3'd3, 16'h5555, 32'hAAAA_AAAA);
        send_request(OP_SET_TIMEOUT, 3'd4, 16'hAAAA, 32'h5555_5555);
        send_request(OP_TICK, 3'd6, 16'd0, 32'd0);
    endtask

    // Set-timeout / start / tick sequences with random content, plus noise
    task automatic test_random_traffic(input int count);
        int first;
        logic [INDEX_W-1:0] idx;
        logic [MS_W-1:0] tmo;
        first = sent_count;
        while (sent_count - first < count)
        begin
            idx = INDEX_W'($urandom_range(0, 7));
            if ($urandom_range(0, 9) < 7)
            begin
                case ($urandom_range(0, 5))
                    0:       tmo = 32'd0;
                    1:       tmo = $urandom_range(1, 1000);
                    4:       tmo = $urandom;
                    5:       tmo = 32'hFFFF_FFFF;
                    default: tmo = $urandom_range(1000, 200000);
                endcase
                send_request(OP_SET_TIMEOUT, idx, TICK_W'($urandom_range(0, 65535)), tmo);
                send_request(($urandom_range(0, 3) == 0) ? OP_RESTART : OP_START, idx,
                             TICK_W'($urandom_range(0, 65535)), $urandom);
                repeat ($urandom_range(1, 5))
                begin
                    case ($urandom_range(0, 7))
                        0: send_request(OP_STOP, idx, TICK_W'($urandom_range(0, 65535)),
                                        $urandom);
                        1: send_request(OP_FORCE, INDEX_W'($urandom_range(0, 7)),
                                        TICK_W'($urandom_range(0, 65535)), $urandom);
                        2: send_request(OP_RESTART, idx, TICK_W'($urandom_range(0, 65535)),
                                        $urandom);
                        default: send_request(OP_TICK, INDEX_W'($urandom_range(0, 7)),
                                              random_tick(), $urandom);
                    endcase
                end
            end
            else
            begin
                send_request(OP_W'($urandom_range(0, 7)), idx,
                             TICK_W'($urandom_range(0, 65535)), $urandom);
            end
        end
    endtask

    // Full-size ticks against a timeout just past three of them and a 1 ms timeout
    task automatic test_long_ticks;
        send_request(OP_SET_TIMEOUT, 3'd2, 16'd0, 32'h0003_0000);
        send_request(OP_START, 3'd2, 16'd0, 32'd0);
        send_request(OP_SET_TIMEOUT, 3'd3, 16'd0, 32'd1);
        send_request(OP_START, 3'd3, 16'd0, 32'd0);
        repeat (6)
            send_request(OP_TICK, 3'd0, 16'hFFFF, 32'd0);
    endtask

    initial
    begin
        bank_ms = '0;
        bank_enable = '0;
        bank_expired = '0;
        for (int i = 0; i < TIMER_COUNT; i++)
        begin
            bank_stamp[i] = '0;
            bank_timeout[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle = 1'b1;
        stall_mode = STALL_RANDOM;
        test_before_first_tick();
        test_command_effects();
        test_unused_opcodes();

        stall_mode = STALL_PERIODIC;
        test_random_traffic(700);

        sender_idle = 1'b0;
        stall_mode = STALL_NONE;
        test_long_ticks();

        test_random_traffic(400);

        sender_idle = 1'b1;
        stall_mode = STALL_HEAVY;
        test_random_traffic(450);

        // drain
        in_valid <= 1'b0;
        stall_mode = STALL_NONE;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed)
            $display("soft_timer_bank_tb: PASS");
        else
            $display("soft_timer_bank_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
